// ----- hw/rtl/llas_pkg.sv -----
`default_nettype none

package llas_pkg;

  localparam int READING_W   = 10;
  localparam int TIME_W      = 32;
  localparam int DURATION_W  = 16;
  localparam int CODE_W      = 2;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam int BEEP_MS_DEFAULT = 200;

  localparam logic [READING_W-1:0]  SAFE_THR_RESET     = 10'd740;
  localparam logic [READING_W-1:0]  MODERATE_THR_RESET = 10'd940;
  localparam logic [DURATION_W-1:0] FIRST_MS_RESET     = 16'd3000;
  localparam logic [DURATION_W-1:0] PAUSE_MS_RESET     = 16'd5000;

  typedef enum logic [CODE_W-1:0] {
    CLASS_SAFE     = 2'd0,
    CLASS_MODERATE = 2'd1,
    CLASS_HIGH     = 2'd2
  } light_class_e;

  typedef enum logic [CODE_W-1:0] {
    PH_OFF   = 2'd0,
    PH_FIRST = 2'd1,
    PH_PAUSE = 2'd2,
    PH_EMERG = 2'd3
  } phase_e;

  // buzzer tones: silent, high pitch or low pitch
  typedef enum logic [CODE_W-1:0] {
    TONE_SILENT = 2'd0,
    TONE_HIGH   = 2'd1,
    TONE_LOW    = 2'd2
  } tone_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SAFE_THR     = 2'd0,
    CFG_MODERATE_THR = 2'd1,
    CFG_FIRST_MS     = 2'd2,
    CFG_PAUSE_MS     = 2'd3
  } cfg_idx_e;

endpackage

`default_nettype wire

// ----- hw/rtl/llas_if.sv -----
`default_nettype none

// sample channel
interface llas_in_if;
  import llas_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [READING_W-1:0] light_reading;
  logic [TIME_W-1:0]    time_ms;

  modport source (output valid, output light_reading, output time_ms, input ready);
  modport sink   (input valid, input light_reading, input time_ms, output ready);
endinterface

// result channel
interface llas_out_if;
  import llas_pkg::*;

  logic              valid;
  logic              ready;
  logic [CODE_W-1:0] light_class;
  logic [CODE_W-1:0] alarm_phase;
  logic [CODE_W-1:0] tone_choice;

  modport source (output valid, output light_class, output alarm_phase,
                  output tone_choice, input ready);
  modport sink   (input valid, input light_class, input alarm_phase,
                  input tone_choice, output ready);
endinterface

`default_nettype wire

// ----- hw/rtl/light_level_alarm_sequencer.sv -----
`default_nettype none

// Channel   Dir  Payload                                  Transfer
// --------  ---  ---------------------------------------  -------------------
// in_ch     in   light_reading[9:0], time_ms[31:0]        valid && ready
// out_ch    out  light_class[1:0], alarm_phase[1:0],      valid && ready
//                tone_choice[1:0]
// cfg       in   cfg_we_i, cfg_idx_i[1:0], cfg_data_i     cfg_we_i high
//
// One sample per cycle when stage 1 is free; the classify / phase update /
// elapsed compare loop closes on the phase and start-time registers. A result
// passes stage 1 (phase, elapsed time) and the output register (fed by the
// beep-period multiply) before it can transfer on out_ch. Reset clears the
// alarm and start time and loads the register defaults. Each stage stalls on
// its own, so an empty stage 1 takes a sample while a result waits.
module light_level_alarm_sequencer #(
  parameter int BeepMs = llas_pkg::BEEP_MS_DEFAULT
) (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_we_i,
  input  wire [llas_pkg::CFG_IDX_W-1:0]    cfg_idx_i,
  input  wire [llas_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  llas_in_if.sink                          in_ch,
  llas_out_if.source                       out_ch
);
  import llas_pkg::*;

  // Exact divide by BeepMs for any 32-bit dividend: multiply by the rounded-up
  // reciprocal, the quotient's low bit lands at bit RecipShift.
  localparam int RecipShift = TIME_W + $clog2(BeepMs);
  localparam int ProdW      = 2 * TIME_W + 1;
  localparam logic [TIME_W:0] Recip =
    (TIME_W + 1)'(((65'd1 << RecipShift) + 65'(BeepMs - 1)) / 65'(BeepMs));

  // configuration registers
  logic [READING_W-1:0]  safe_thr_q, moderate_thr_q;
  logic [DURATION_W-1:0] first_ms_q, pause_ms_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      safe_thr_q     <= SAFE_THR_RESET;
      moderate_thr_q <= MODERATE_THR_RESET;
      first_ms_q     <= FIRST_MS_RESET;
      pause_ms_q     <= PAUSE_MS_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SAFE_THR:     safe_thr_q     <= cfg_data_i[READING_W-1:0];
        CFG_MODERATE_THR: moderate_thr_q <= cfg_data_i[READING_W-1:0];
        CFG_FIRST_MS:     first_ms_q     <= cfg_data_i[DURATION_W-1:0];
        CFG_PAUSE_MS:     pause_ms_q     <= cfg_data_i[DURATION_W-1:0];
      endcase
    end
  end

  // pipeline handshake: each stage loads when empty or when it drains
  logic s1_valid_q, out_valid_q;
  logic out_free, s1_free, in_xfer;

  assign out_free    = !out_valid_q || out_ch.ready;
  assign s1_free     = !s1_valid_q || out_free;
  assign in_ch.ready = s1_free;
  assign in_xfer     = in_ch.valid && s1_free;

  // alarm state
  phase_e            phase_q, phase_d;
  logic [TIME_W-1:0] start_q, start_d;
  phase_e            phase_entry;
  logic [TIME_W-1:0] start_entry;
  logic [TIME_W-1:0] elapsed;
  light_class_e      cls;

  always_comb begin
    priority if (in_ch.light_reading <= safe_thr_q) begin
      cls = CLASS_SAFE;
    end else if (in_ch.light_reading <= moderate_thr_q) begin
      cls = CLASS_MODERATE;
    end else begin
      cls = CLASS_HIGH;
    end
  end

  // next state: drop to off on a non-high reading, arm on the first high one,
  // then advance at most one phase on the elapsed time
  always_comb begin
    phase_entry = phase_q;
    start_entry = start_q;
    if (cls != CLASS_HIGH) begin
      phase_entry = PH_OFF;
    end else if (phase_q == PH_OFF) begin
      phase_entry = PH_FIRST;
      start_entry = in_ch.time_ms;
    end
    elapsed = in_ch.time_ms - start_entry;
    phase_d = phase_entry;
    start_d = start_entry;
    unique case (phase_entry)
      PH_FIRST: begin
        if (elapsed >= TIME_W'(first_ms_q)) begin
          phase_d = PH_PAUSE;
          start_d = in_ch.time_ms;
        end
      end
      PH_PAUSE: begin
        if (elapsed >= TIME_W'(pause_ms_q)) begin
          phase_d = PH_EMERG;
          start_d = in_ch.time_ms;
        end
      end
      PH_EMERG, PH_OFF: begin
      end
    endcase
  end

  // outputs of the sequencer: steady tone in the first alarm, emergency tone
  // only on samples that find the phase already running
  tone_e tone_base;
  logic  emerg_tone;

  always_comb begin
    unique case (phase_d)
      PH_FIRST:                  tone_base = TONE_HIGH;
      PH_OFF, PH_PAUSE, PH_EMERG: tone_base = TONE_SILENT;
    endcase
    emerg_tone = (phase_entry == PH_EMERG);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_OFF;
      start_q <= '0;
    end else if (in_xfer) begin
      phase_q <= phase_d;
      start_q <= start_d;
    end
  end

  // stage 1: hold the updated phase and elapsed time
  light_class_e      s1_cls_q;
  phase_e            s1_phase_q;
  tone_e             s1_tone_q;
  logic              s1_emerg_q;
  logic [TIME_W-1:0] s1_elapsed_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (s1_free) begin
      s1_valid_q <= in_ch.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_cls_q     <= cls;
      s1_phase_q   <= phase_d;
      s1_tone_q    <= tone_base;
      s1_emerg_q   <= emerg_tone;
      s1_elapsed_q <= elapsed;
    end
  end

  // beep parity: low bit of elapsed / BeepMs
  logic [ProdW-1:0] prod;
  logic             beep_odd;
  tone_e            tone_fin;

  assign prod     = ProdW'(s1_elapsed_q) * ProdW'(Recip);
  assign beep_odd = prod[RecipShift];

  always_comb begin
    if (s1_emerg_q) begin
      tone_fin = beep_odd ? TONE_LOW : TONE_HIGH;
    end else begin
      tone_fin = s1_tone_q;
    end
  end

  // output register
  light_class_e out_cls_q;
  phase_e       out_phase_q;
  tone_e        out_tone_q;
  logic         s1_advance;

  assign s1_advance = s1_valid_q && out_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_advance) begin
      out_cls_q   <= s1_cls_q;
      out_phase_q <= s1_phase_q;
      out_tone_q  <= tone_fin;
    end
  end

  assign out_ch.valid       = out_valid_q;
  assign out_ch.light_class = out_cls_q;
  assign out_ch.alarm_phase = out_phase_q;
  assign out_ch.tone_choice = out_tone_q;

endmodule

`default_nettype wire
